[src/diff_drive_move_list_regulator_assert.svh]
// Assertion macros for the move-list regulator.
// Needs i_clk and i_rst_n in the scope of the including module.
`ifndef DIFF_DRIVE_MOVE_LIST_REGULATOR_ASSERT_SVH
`define DIFF_DRIVE_MOVE_LIST_REGULATOR_ASSERT_SVH

// same-cycle implication, off during reset
`define DDMLR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ddmlr: assertion failed");

// next-cycle implication, off during reset
`define DDMLR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ddmlr: assertion failed");

`endif

[src/ddmlr_pkg.sv]
// Shared constants for the move-list regulator: table depth, field widths,
// register indexes and reset values. No dependencies.
package ddmlr_pkg;

    localparam int MAX_MOVES = 16;
    localparam int PTR_W     = $clog2(MAX_MOVES);
    localparam int CNT_W     = ($clog2(MAX_MOVES + 1) > 5) ? $clog2(MAX_MOVES + 1) : 5;

    localparam int MC_W      = 5;
    localparam int GAIN_W    = 16;
    localparam int ENC_W     = 32;
    localparam int IDX_W     = 4;
    localparam int TGT_W     = 16;
    localparam int DRV_W     = 9;
    localparam int ACT_W     = 4;
    localparam int ENTRY_W   = 2 * TGT_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int SUM_W   = ENC_W + 1;
    localparam int REFD_W  = ENC_W;
    localparam int REFA_W  = ENC_W + 1;
    localparam int POS_W   = ENC_W + 3;
    localparam int ERR_W   = POS_W + 8;
    localparam int LO_W    = 22;
    localparam int MUL_A_W = GAIN_W + 1;
    localparam int MUL_B_W = LO_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = ERR_W + GAIN_W + 2;
    localparam int FRAC_W  = 16;
    localparam int Q_W     = ACC_W - FRAC_W;
    localparam int DRV_MAX = 255;

    localparam logic [CFG_IDX_W-1:0] REG_MOVE_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP_DISTANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KP_ANGLE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_MM    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_DEG   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_TOL    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_TOL   = 3'd6;

    localparam logic [MC_W-1:0]   RST_MOVE_COUNT = 5'd1;
    localparam logic [GAIN_W-1:0] RST_GAIN       = 16'd256;
    localparam logic [GAIN_W-1:0] RST_TOL        = 16'd10;

endpackage

[src/diff_drive_move_list_regulator.sv]
// Move-list regulator: differential-drive distance/angle P controller.
// A load beat writes the move table RAM. A tick beat steps through the states TGT_D,
// TGT_A, ERR_A, CD_HI, CA_LO, CA_HI, CA_ADD, MIX and OUT to its result register, using one
// shared 17x23 multiplier six times. One tick is in flight at a time, and OUT holds while
// the result register is full; a new beat is taken while the last result waits.
// Synchronous active-low reset: pointer and references to zero, registers to defaults.
// Uses ddmlr_pkg and ddmlr_ram.
module diff_drive_move_list_regulator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [ddmlr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ddmlr_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_action,
    input  logic signed [ddmlr_pkg::ENC_W-1:0]     i_count_right,
    input  logic signed [ddmlr_pkg::ENC_W-1:0]     i_count_left,
    input  logic [ddmlr_pkg::IDX_W-1:0]            i_entry_index,
    input  logic signed [ddmlr_pkg::TGT_W-1:0]     i_entry_distance_mm,
    input  logic signed [ddmlr_pkg::TGT_W-1:0]     i_entry_angle_deg,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [ddmlr_pkg::DRV_W-1:0]     o_drive_right,
    output logic signed [ddmlr_pkg::DRV_W-1:0]     o_drive_left,
    output logic [ddmlr_pkg::ACT_W-1:0]            o_active_move,
    output logic                                   o_on_target
);
    import ddmlr_pkg::*;

    `include "diff_drive_move_list_regulator_assert.svh"

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_TGT_D  = 4'd1;
    localparam logic [3:0] ST_TGT_A  = 4'd2;
    localparam logic [3:0] ST_ERR_A  = 4'd3;
    localparam logic [3:0] ST_CD_HI  = 4'd4;
    localparam logic [3:0] ST_CA_LO  = 4'd5;
    localparam logic [3:0] ST_CA_HI  = 4'd6;
    localparam logic [3:0] ST_CA_ADD = 4'd7;
    localparam logic [3:0] ST_MIX    = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;

    function automatic logic signed [DRV_W-1:0] drive_sat(input logic signed [ACC_W-1:0] s);
        logic signed [Q_W-1:0] q;
        q = Q_W'(s >>> FRAC_W);
        if (s[ACC_W-1] && (s[FRAC_W-1:0] != '0)) begin
            q = q + Q_W'(1);
        end
        if (q > Q_W'(DRV_MAX)) begin
            drive_sat = DRV_W'(DRV_MAX);
        end else if (q < -Q_W'(DRV_MAX)) begin
            drive_sat = DRV_W'(-DRV_MAX);
        end else begin
            drive_sat = DRV_W'(q);
        end
    endfunction

    // config
    logic [MC_W-1:0]   r_move_count;
    logic [GAIN_W-1:0] r_kp_d;
    logic [GAIN_W-1:0] r_kp_a;
    logic [GAIN_W-1:0] r_tpm;
    logic [GAIN_W-1:0] r_tpd;
    logic [GAIN_W-1:0] r_tol_d;
    logic [GAIN_W-1:0] r_tol_a;

    // control
    logic [3:0]        r_state;
    logic [PTR_W-1:0]  r_ptr;
    logic signed [REFD_W-1:0] r_ref_d;
    logic signed [REFA_W-1:0] r_ref_a;
    logic              r_out_valid;

    // datapath
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  r_diff;
    logic signed [POS_W-1:0]  r_pos_d;
    logic signed [POS_W-1:0]  r_pos_a;
    logic signed [ERR_W-1:0]  r_err_d;
    logic signed [ERR_W-1:0]  r_err_a;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_cd;
    logic signed [ACC_W-1:0]  r_ca;
    logic signed [ACC_W-1:0]  r_sr;
    logic signed [ACC_W-1:0]  r_sl;
    logic              r_near_d;
    logic              r_near_a;

    // result beat
    logic signed [DRV_W-1:0] r_drive_right;
    logic signed [DRV_W-1:0] r_drive_left;
    logic [ACT_W-1:0]        r_active_move;
    logic                    r_on_target;

    logic              w_in_accept;
    logic              w_idx_ok;
    logic              w_ram_we;
    logic              w_ram_re;
    logic [ENTRY_W-1:0] w_rdata;
    logic signed [TGT_W-1:0] w_tbl_d;
    logic signed [TGT_W-1:0] w_tbl_a;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic [ERR_W-1:0]  w_abs_d;
    logic [ERR_W-1:0]  w_abs_a;
    logic [ERR_W-1:0]  w_tol_d;
    logic [ERR_W-1:0]  w_tol_a;
    logic [CNT_W-1:0]  w_count_eff;
    logic              w_advance;
    logic [PTR_W-1:0]  w_ptr_next;
    logic              w_out_free;
    logic              w_result_load;

    assign o_in_ready    = (r_state == ST_IDLE);
    assign w_in_accept   = i_in_valid && o_in_ready;
    assign w_idx_ok      = int'(i_entry_index) < MAX_MOVES;
    assign w_ram_we      = w_in_accept && i_action && w_idx_ok;
    assign w_ram_re      = w_in_accept && !i_action;
    assign w_out_free    = !r_out_valid || i_out_ready;
    assign w_result_load = (r_state == ST_OUT) && w_out_free;

    ddmlr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_MOVES)
    ) u_move_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (PTR_W'(i_entry_index)),
        .i_wdata ({i_entry_distance_mm, i_entry_angle_deg}),
        .i_re    (w_ram_re),
        .i_raddr (r_ptr),
        .o_rdata (w_rdata)
    );

    assign w_tbl_d = w_rdata[ENTRY_W-1:TGT_W];
    assign w_tbl_a = w_rdata[TGT_W-1:0];

    // shared multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            ST_TGT_D: begin
                w_mul_a = {1'b0, r_tpm};
                w_mul_b = MUL_B_W'(w_tbl_d);
            end
            ST_TGT_A: begin
                w_mul_a = {1'b0, r_tpd};
                w_mul_b = MUL_B_W'(w_tbl_a);
            end
            ST_ERR_A: begin
                w_mul_a = {1'b0, r_kp_d};
                w_mul_b = {1'b0, r_err_d[LO_W-1:0]};
            end
            ST_CD_HI: begin
                w_mul_a = {1'b0, r_kp_d};
                w_mul_b = MUL_B_W'($signed(r_err_d[ERR_W-1:LO_W]));
            end
            ST_CA_LO: begin
                w_mul_a = {1'b0, r_kp_a};
                w_mul_b = {1'b0, r_err_a[LO_W-1:0]};
            end
            ST_CA_HI: begin
                w_mul_a = {1'b0, r_kp_a};
                w_mul_b = MUL_B_W'($signed(r_err_a[ERR_W-1:LO_W]));
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod  = w_mul_a * w_mul_b;
    assign w_abs_d = r_err_d[ERR_W-1] ? ERR_W'(-r_err_d) : ERR_W'(r_err_d);
    assign w_abs_a = r_err_a[ERR_W-1] ? ERR_W'(-r_err_a) : ERR_W'(r_err_a);
    assign w_tol_d = ERR_W'({r_tol_d, 8'h00});
    assign w_tol_a = ERR_W'({r_tol_a, 8'h00});

    always_comb begin
        if (r_move_count == '0) begin
            w_count_eff = CNT_W'(1);
        end else if (CNT_W'(r_move_count) > CNT_W'(MAX_MOVES)) begin
            w_count_eff = CNT_W'(MAX_MOVES);
        end else begin
            w_count_eff = CNT_W'(r_move_count);
        end
    end

    assign w_advance  = r_near_d && r_near_a && ((CNT_W'(r_ptr) + CNT_W'(1)) < w_count_eff);
    assign w_ptr_next = w_advance ? r_ptr + PTR_W'(1) : r_ptr;

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (w_ram_re) begin
            r_sum  <= SUM_W'(i_count_right) + SUM_W'(i_count_left);
            r_diff <= SUM_W'(i_count_right) - SUM_W'(i_count_left);
        end
        case (r_state)
            ST_TGT_D: begin
                r_pos_d <= POS_W'(r_sum) - (POS_W'(r_ref_d) <<< 1);
                r_pos_a <= POS_W'(r_diff) - POS_W'(r_ref_a);
            end
            ST_TGT_A: begin
                r_err_d <= ERR_W'(r_prod) - (ERR_W'(r_pos_d) <<< 7);
            end
            ST_ERR_A: begin
                r_err_a  <= ERR_W'(r_prod) - (ERR_W'(r_pos_a) <<< 8);
                r_near_d <= w_abs_d < w_tol_d;
            end
            ST_CD_HI: begin
                r_cd     <= ACC_W'(r_prod);
                r_near_a <= w_abs_a < w_tol_a;
            end
            ST_CA_LO: begin
                r_cd <= r_cd + (ACC_W'(r_prod) <<< LO_W);
            end
            ST_CA_HI: begin
                r_ca <= ACC_W'(r_prod);
            end
            ST_CA_ADD: begin
                r_ca <= r_ca + (ACC_W'(r_prod) <<< LO_W);
            end
            ST_MIX: begin
                r_sr <= r_cd + r_ca;
                r_sl <= r_cd - r_ca;
            end
            ST_OUT: begin
                if (w_out_free) begin
                    r_drive_right <= drive_sat(r_sr);
                    r_drive_left  <= drive_sat(r_sl);
                    r_active_move <= ACT_W'(w_ptr_next);
                    r_on_target   <= r_near_d && r_near_a;
                end
            end
            default: begin
            end
        endcase
    end

    // control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ptr        <= '0;
            r_ref_d      <= '0;
            r_ref_a      <= '0;
            r_out_valid  <= 1'b0;
            r_move_count <= RST_MOVE_COUNT;
            r_kp_d       <= RST_GAIN;
            r_kp_a       <= RST_GAIN;
            r_tpm        <= RST_GAIN;
            r_tpd        <= RST_GAIN;
            r_tol_d      <= RST_TOL;
            r_tol_a      <= RST_TOL;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_MOVE_COUNT:  r_move_count <= i_cfg_data[MC_W-1:0];
                    REG_KP_DISTANCE: r_kp_d       <= i_cfg_data;
                    REG_KP_ANGLE:    r_kp_a       <= i_cfg_data;
                    REG_TICKS_MM:    r_tpm        <= i_cfg_data;
                    REG_TICKS_DEG:   r_tpd        <= i_cfg_data;
                    REG_DIST_TOL:    r_tol_d      <= i_cfg_data;
                    REG_ANGLE_TOL:   r_tol_a      <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (w_result_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_ram_re) begin
                        r_state <= ST_TGT_D;
                    end
                end
                ST_TGT_D:  r_state <= ST_TGT_A;
                ST_TGT_A:  r_state <= ST_ERR_A;
                ST_ERR_A:  r_state <= ST_CD_HI;
                ST_CD_HI:  r_state <= ST_CA_LO;
                ST_CA_LO:  r_state <= ST_CA_HI;
                ST_CA_HI:  r_state <= ST_CA_ADD;
                ST_CA_ADD: r_state <= ST_MIX;
                ST_MIX:    r_state <= ST_OUT;
                ST_OUT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                        if (w_advance) begin
                            r_ptr   <= w_ptr_next;
                            r_ref_d <= REFD_W'(r_sum >>> 1);
                            r_ref_a <= r_diff;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive_right = r_drive_right;
    assign o_drive_left  = r_drive_left;
    assign o_active_move = r_active_move;
    assign o_on_target   = r_on_target;

    `DDMLR_ASSERT_IMP(a_ram_write_idle, w_ram_we, r_state == ST_IDLE)
    `DDMLR_ASSERT_NEXT(a_ptr_holds, !w_result_load, r_ptr == $past(r_ptr))
    `DDMLR_ASSERT_NEXT(a_result_then_idle, w_result_load, o_out_valid && (r_state == ST_IDLE))
    `DDMLR_ASSERT_NEXT(a_advance_on_target, w_result_load && w_advance, o_on_target)

endmodule

[src/ddmlr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; contents are not reset.
module ddmlr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
